/* src/assert_macros.svh */
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is held
`define OCV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked check that also holds during reset
`define OCV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

/* src/ocv_pkg.sv */
// Shared constants, types and helpers of the battery charge estimator
package ocv_pkg;

  localparam int STORE_DEPTH = 64;
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam int ADC_W       = 12;
  localparam int SMP_W       = 13;
  localparam int EST_W       = 21;
  localparam int GAIN_W      = 9;
  localparam int REG_W       = 8;
  localparam int CFG_AW      = 8;
  localparam int CFG_DW      = 9;
  localparam int PCT_W       = 7;
  localparam int SUM_W       = SMP_W + AW;
  localparam int EN_W        = 2 * SMP_W + AW;
  localparam int DIV_CW      = $clog2(SUM_W + 1);

  localparam logic [EST_W-1:0]  EST_RST     = EST_W'(4200 * 256);
  localparam logic [SMP_W-1:0]  READING_RST = SMP_W'(4096);
  localparam logic [PCT_W-1:0]  CHARGE_RST  = PCT_W'(73);
  localparam logic [GAIN_W-1:0] GAIN_RST    = GAIN_W'(77);
  localparam logic [REG_W-1:0]  LIMIT_RST   = REG_W'(3);
  localparam logic [REG_W-1:0]  INIT_RST    = REG_W'(5);
  localparam logic [REG_W-1:0]  STEP_RST    = REG_W'(10);

  localparam logic [CFG_AW-1:0] REG_GAIN  = CFG_AW'(0);
  localparam logic [CFG_AW-1:0] REG_LIMIT = CFG_AW'(1);
  localparam logic [CFG_AW-1:0] REG_INIT  = CFG_AW'(2);
  localparam logic [CFG_AW-1:0] REG_STEP  = CFG_AW'(3);

  typedef enum logic [4:0] {
    OP_IDLE, OP_LOAD, OP_EST_MUL, OP_EST_UPD, OP_INS_RD, OP_INS_CMP, OP_POST,
    OP_W_INIT, OP_SUM_RD, OP_SUM_ACC, OP_DIV_GO, OP_DIV_WAIT, OP_VAR_RD,
    OP_VAR_SQ, OP_VAR_ACC, OP_CHECK, OP_CH_MV, OP_CH_LIN, OP_CH_PROD,
    OP_CH_DIFF, OP_CH_QUAD, OP_CH_BLEND, OP_FIN
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic ins_zero;
    logic ins_shift;
    logic win_full;
    logic last;
    logic div_done;
    logic accept;
    logic out_free;
  } stat_t;

  function automatic logic [AW-1:0] clamp_win(input logic [REG_W:0] w);
    logic [AW-1:0] r;
    if (w == '0) begin
      r = AW'(1);
    end else if (w > (REG_W+1)'(STORE_DEPTH - 1)) begin
      r = AW'(STORE_DEPTH - 1);
    end else begin
      r = w[AW-1:0];
    end
    return r;
  endfunction

endpackage

/* src/ocv_ifs.sv */
// Valid/ready channel interfaces: sample input, result output, register writes
interface ocv_in_if;
  logic                          valid;
  logic                          ready;
  logic [ocv_pkg::ADC_W-1:0]     adc_sample;
  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

interface ocv_out_if;
  logic                          valid;
  logic                          ready;
  logic [ocv_pkg::SMP_W-1:0]     smoothed_sample;
  logic                          window_done;
  logic                          window_accepted;
  logic [ocv_pkg::SMP_W-1:0]     stable_reading;
  logic [ocv_pkg::PCT_W-1:0]     charge_percent;
  modport source (output valid, output smoothed_sample, output window_done,
                  output window_accepted, output stable_reading,
                  output charge_percent, input ready);
  modport sink   (input valid, input smoothed_sample, input window_done,
                  input window_accepted, input stable_reading,
                  input charge_percent, output ready);
endinterface

interface ocv_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ocv_pkg::CFG_AW-1:0]    index;
  logic [ocv_pkg::CFG_DW-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/ocv_ram.sv */
// Generic single-write, single-read RAM with registered read data
module ocv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/ocv_div.sv */
// Restoring divider, one quotient bit per cycle, for the window average
module ocv_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ocv_pkg::SUM_W-1:0]   dividend,
  input  logic [ocv_pkg::AW-1:0]      divisor,
  output logic                        done,
  output logic [ocv_pkg::SUM_W-1:0]   quotient
);

  logic [ocv_pkg::SUM_W-1:0]  q_r, q_nxt;
  logic [ocv_pkg::AW-1:0]     rem_r, rem_nxt;
  logic [ocv_pkg::AW-1:0]     dvs_r;
  logic [ocv_pkg::DIV_CW-1:0] cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [ocv_pkg::AW:0]       trial;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, q_r[ocv_pkg::SUM_W-1]};
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      cnt_nxt  = ocv_pkg::DIV_CW'(ocv_pkg::SUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = ocv_pkg::AW'(trial - {1'b0, dvs_r});
        q_nxt   = {q_r[ocv_pkg::SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[ocv_pkg::AW-1:0];
        q_nxt   = {q_r[ocv_pkg::SUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - ocv_pkg::DIV_CW'(1);
      if (cnt_r == ocv_pkg::DIV_CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

/* src/ocv_ctrl.sv */
// Sequencer of the estimator: walks one word through smoothing, insertion and window end
module ocv_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  ocv_pkg::stat_t  st,
  output ocv_pkg::cmd_t   cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_EST_MUL, S_EST_UPD, S_INS_RD, S_INS_CMP, S_POST, S_W_INIT,
    S_SUM_RD, S_SUM_ACC, S_DIV_GO, S_DIV_WAIT, S_VAR_RD, S_VAR_SQ, S_VAR_ACC,
    S_CHECK, S_CH_MV, S_CH_LIN, S_CH_PROD, S_CH_DIFF, S_CH_QUAD, S_CH_BLEND,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = ocv_pkg::OP_IDLE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = ocv_pkg::OP_LOAD;
          state_nxt = S_EST_MUL;
        end
      end
      S_EST_MUL: begin
        cmd.op    = ocv_pkg::OP_EST_MUL;
        state_nxt = S_EST_UPD;
      end
      S_EST_UPD: begin
        cmd.op    = ocv_pkg::OP_EST_UPD;
        state_nxt = S_INS_RD;
      end
      S_INS_RD: begin
        cmd.op    = ocv_pkg::OP_INS_RD;
        state_nxt = st.ins_zero ? S_POST : S_INS_CMP;
      end
      S_INS_CMP: begin
        cmd.op    = ocv_pkg::OP_INS_CMP;
        state_nxt = st.ins_shift ? S_INS_RD : S_POST;
      end
      S_POST: begin
        cmd.op    = ocv_pkg::OP_POST;
        state_nxt = st.win_full ? S_W_INIT : S_FIN;
      end
      S_W_INIT: begin
        cmd.op    = ocv_pkg::OP_W_INIT;
        state_nxt = S_SUM_RD;
      end
      S_SUM_RD: begin
        cmd.op    = ocv_pkg::OP_SUM_RD;
        state_nxt = S_SUM_ACC;
      end
      S_SUM_ACC: begin
        cmd.op    = ocv_pkg::OP_SUM_ACC;
        state_nxt = st.last ? S_DIV_GO : S_SUM_RD;
      end
      S_DIV_GO: begin
        cmd.op    = ocv_pkg::OP_DIV_GO;
        state_nxt = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        cmd.op = ocv_pkg::OP_DIV_WAIT;
        if (st.div_done) begin
          state_nxt = S_VAR_RD;
        end
      end
      S_VAR_RD: begin
        cmd.op    = ocv_pkg::OP_VAR_RD;
        state_nxt = S_VAR_SQ;
      end
      S_VAR_SQ: begin
        cmd.op    = ocv_pkg::OP_VAR_SQ;
        state_nxt = S_VAR_ACC;
      end
      S_VAR_ACC: begin
        cmd.op    = ocv_pkg::OP_VAR_ACC;
        state_nxt = st.last ? S_CHECK : S_VAR_RD;
      end
      S_CHECK: begin
        cmd.op    = ocv_pkg::OP_CHECK;
        state_nxt = st.accept ? S_CH_MV : S_FIN;
      end
      S_CH_MV: begin
        cmd.op    = ocv_pkg::OP_CH_MV;
        state_nxt = S_CH_LIN;
      end
      S_CH_LIN: begin
        cmd.op    = ocv_pkg::OP_CH_LIN;
        state_nxt = S_CH_PROD;
      end
      S_CH_PROD: begin
        cmd.op    = ocv_pkg::OP_CH_PROD;
        state_nxt = S_CH_DIFF;
      end
      S_CH_DIFF: begin
        cmd.op    = ocv_pkg::OP_CH_DIFF;
        state_nxt = S_CH_QUAD;
      end
      S_CH_QUAD: begin
        cmd.op    = ocv_pkg::OP_CH_QUAD;
        state_nxt = S_CH_BLEND;
      end
      S_CH_BLEND: begin
        cmd.op    = ocv_pkg::OP_CH_BLEND;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.op = ocv_pkg::OP_FIN;
        if (st.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

/* src/ocv_dp.sv */
// Datapath: smoother, sorted window store, window statistics and charge fit
module ocv_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ocv_pkg::cmd_t              cmd,
  output ocv_pkg::stat_t             st,
  input  logic [ocv_pkg::ADC_W-1:0]  adc_sample,
  ocv_cfg_if.sink                    cfg,
  ocv_out_if.source                  res
);

  localparam int AW    = ocv_pkg::AW;
  localparam int SMP_W = ocv_pkg::SMP_W;
  localparam int EST_W = ocv_pkg::EST_W;

  // configuration
  logic [ocv_pkg::GAIN_W-1:0] gain_r;
  logic [ocv_pkg::REG_W-1:0]  limit_r, step_r;

  // smoother and window
  logic [EST_W-1:0]            est_r;
  logic [ocv_pkg::ADC_W-1:0]   smp_r;
  logic [29:0]                 p1_r;
  logic [20:0]                 p2_r;
  logic [SMP_W-1:0]            val_r;
  logic [AW-1:0]               fill_r, win_r, j_r, cnt_r, ofs_r, idx_r;
  logic [ocv_pkg::SUM_W-1:0]   sum_r;
  logic [SMP_W-1:0]            avg_r;
  logic [2*SMP_W-1:0]          sq_r;
  logic [ocv_pkg::EN_W-1:0]    en_r;
  logic                        done_f_r, acc_f_r;
  logic [SMP_W-1:0]            reading_r;
  logic [ocv_pkg::PCT_W-1:0]   charge_r;

  // charge fit
  logic [14:0]                 mv_r;
  logic [6:0]                  lin_r, quad_r;
  logic [12:0]                 m_r;
  logic [20:0]                 t_r;
  logic                        big_r, qlow_r, qhigh_r;
  logic [33:0]                 prod_r;
  logic [20:0]                 y_r;

  // output word
  logic                        out_valid_r;
  logic [SMP_W-1:0]            o_smp_r, o_read_r;
  logic                        o_done_r, o_acc_r;
  logic [ocv_pkg::PCT_W-1:0]   o_pct_r;

  // RAM ports
  logic                        we, re;
  logic [AW-1:0]               waddr, raddr;
  logic [SMP_W-1:0]            wdata, rdata;

  logic                        div_start, div_done;
  logic [ocv_pkg::SUM_W-1:0]   div_q;

  logic [ocv_pkg::GAIN_W-1:0]  g_sat;
  logic [30:0]                 est_sum;
  logic [AW+7:0]               c_prod;
  logic [AW-1:0]               cnt_w, ofs_w;
  logic [SMP_W-1:0]            dif;
  logic [ocv_pkg::REG_W+AW-1:0] lim_prod;
  logic [14:0]                 m_w;
  logic [10:0]                 lin_x;
  logic [6:0]                  lin_w, qv;
  logic [9:0]                  blend;

  ocv_ram #(.WIDTH(SMP_W), .DEPTH(ocv_pkg::STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  ocv_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (cnt_r),
    .done     (div_done),
    .quotient (div_q)
  );

  assign div_start = (cmd.op == ocv_pkg::OP_DIV_GO);
  assign cfg.ready = 1'b1;

  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = j_r;
    wdata = val_r;
    raddr = j_r - AW'(1);
    case (cmd.op)
      ocv_pkg::OP_INS_RD: begin
        if (j_r == '0) begin
          we = 1'b1;
        end else begin
          re = 1'b1;
        end
      end
      ocv_pkg::OP_INS_CMP: begin
        // insertion step: shift the larger entry up, or drop the new word in
        we    = 1'b1;
        wdata = st.ins_shift ? rdata : val_r;
      end
      ocv_pkg::OP_SUM_RD, ocv_pkg::OP_VAR_RD: begin
        re    = 1'b1;
        raddr = ofs_r + idx_r;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    g_sat    = (gain_r > ocv_pkg::GAIN_W'(256)) ? ocv_pkg::GAIN_W'(256) : gain_r;
    est_sum  = 31'(p1_r) + 31'({p2_r, 8'h00});
    // n/5 as n*205 >> 10, exact over the window range
    c_prod   = (AW+8)'(win_r) * (AW+8)'(205);
    cnt_w    = AW'(c_prod >> 10);
    if (cnt_w == '0) begin
      cnt_w = AW'(1);
    end
    ofs_w    = AW'((win_r - cnt_w) >> 1);
    dif      = (rdata >= avg_r) ? (rdata - avg_r) : (avg_r - rdata);
    lim_prod = (ocv_pkg::REG_W+AW)'(limit_r) * (ocv_pkg::REG_W+AW)'(cnt_r);
    m_w      = (mv_r < 15'd3385) ? 15'd3385 : mv_r;
    lin_x    = 11'(mv_r - 15'd2800);
    if (mv_r >= 15'd4200) begin
      lin_w = 7'd100;
    end else if (mv_r <= 15'd2800) begin
      lin_w = 7'd0;
    end else begin
      // x/14 as x*4682 >> 16 for x below 1400
      lin_w = 7'((27'(lin_x) * 27'd4682) >> 16);
    end
    // y/15625 as y*1099512 >> 34
    qv       = 7'((42'(y_r) * 42'd1099512) >> 34);
    blend    = 10'(7 * 10'(lin_r)) + 10'(3 * 10'(quad_r));
  end

  assign st.ins_zero  = (j_r == '0);
  assign st.ins_shift = (rdata > val_r);
  assign st.win_full  = ((AW+1)'(fill_r) + (AW+1)'(1)) >= (AW+1)'(win_r);
  assign st.last      = (idx_r == cnt_r - AW'(1));
  assign st.div_done  = div_done;
  assign st.accept    = {en_r, 1'b0} <= (ocv_pkg::EN_W+1)'(lim_prod);
  assign st.out_free  = !out_valid_r || res.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r      <= ocv_pkg::GAIN_RST;
      limit_r     <= ocv_pkg::LIMIT_RST;
      step_r      <= ocv_pkg::STEP_RST;
      est_r       <= ocv_pkg::EST_RST;
      fill_r      <= '0;
      win_r       <= ocv_pkg::clamp_win({1'b0, ocv_pkg::INIT_RST});
      reading_r   <= ocv_pkg::READING_RST;
      charge_r    <= ocv_pkg::CHARGE_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          ocv_pkg::REG_GAIN:  gain_r  <= cfg.data;
          ocv_pkg::REG_LIMIT: limit_r <= cfg.data[ocv_pkg::REG_W-1:0];
          ocv_pkg::REG_INIT: begin
            win_r  <= ocv_pkg::clamp_win({1'b0, cfg.data[ocv_pkg::REG_W-1:0]});
            fill_r <= '0;
          end
          ocv_pkg::REG_STEP:  step_r  <= cfg.data[ocv_pkg::REG_W-1:0];
          default: begin
          end
        endcase
      end
      case (cmd.op)
        ocv_pkg::OP_EST_UPD: est_r <= est_sum[EST_W+7:8];
        ocv_pkg::OP_POST: begin
          fill_r <= st.win_full ? '0 : fill_r + AW'(1);
        end
        ocv_pkg::OP_CHECK: begin
          if (st.accept) begin
            reading_r <= avg_r;
          end
          win_r <= ocv_pkg::clamp_win((ocv_pkg::REG_W+1)'(win_r) +
                                      (ocv_pkg::REG_W+1)'(step_r));
        end
        ocv_pkg::OP_CH_BLEND: charge_r <= 7'((18'(blend) * 18'd205) >> 11);
        default: begin
        end
      endcase
      if (cmd.op == ocv_pkg::OP_FIN && st.out_free) begin
        out_valid_r <= 1'b1;
      end else if (res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      ocv_pkg::OP_LOAD: begin
        smp_r    <= adc_sample;
        done_f_r <= 1'b0;
        acc_f_r  <= 1'b0;
      end
      ocv_pkg::OP_EST_MUL: begin
        p1_r <= 30'(ocv_pkg::GAIN_W'(256) - g_sat) * 30'(est_r);
        p2_r <= 21'(g_sat) * 21'(smp_r);
      end
      ocv_pkg::OP_EST_UPD: begin
        val_r <= est_sum[EST_W+7:16];
        j_r   <= fill_r;
      end
      ocv_pkg::OP_INS_CMP: begin
        if (st.ins_shift) begin
          j_r <= j_r - AW'(1);
        end
      end
      ocv_pkg::OP_POST: begin
        if (st.win_full) begin
          done_f_r <= 1'b1;
        end
      end
      ocv_pkg::OP_W_INIT: begin
        cnt_r <= cnt_w;
        ofs_r <= ofs_w;
        idx_r <= '0;
        sum_r <= '0;
      end
      ocv_pkg::OP_SUM_ACC: begin
        sum_r <= sum_r + ocv_pkg::SUM_W'(rdata);
        idx_r <= idx_r + AW'(1);
      end
      ocv_pkg::OP_DIV_GO: begin
        idx_r <= '0;
        en_r  <= '0;
      end
      ocv_pkg::OP_DIV_WAIT: begin
        if (div_done) begin
          avg_r <= div_q[SMP_W-1:0];
        end
      end
      ocv_pkg::OP_VAR_SQ: sq_r <= (2*SMP_W)'(dif) * (2*SMP_W)'(dif);
      ocv_pkg::OP_VAR_ACC: begin
        en_r  <= en_r + ocv_pkg::EN_W'(sq_r);
        idx_r <= idx_r + AW'(1);
      end
      ocv_pkg::OP_CHECK: begin
        if (st.accept) begin
          acc_f_r <= 1'b1;
        end
      end
      ocv_pkg::OP_CH_MV: mv_r <= 15'((27'(reading_r) * 27'd11200) >> 12);
      ocv_pkg::OP_CH_LIN: begin
        lin_r <= lin_w;
        big_r <= (m_w >= 15'd8192);
        m_r   <= m_w[12:0];
        t_r   <= 21'd1026400 - 21'(21'(m_w[12:0]) * 21'd119);
      end
      ocv_pkg::OP_CH_PROD: prod_r <= 34'(m_r) * 34'(t_r);
      ocv_pkg::OP_CH_DIFF: begin
        // quadratic below 10 (or negative) clamps to 10, at 100 or more to 100
        qlow_r  <= big_r || (prod_r < 34'd2120300000);
        qhigh_r <= !big_r && (prod_r >= 34'd2210300000);
        y_r     <= 21'((prod_r - 34'd2110300000) >> 6);
      end
      ocv_pkg::OP_CH_QUAD: begin
        quad_r <= qlow_r ? 7'd10 : (qhigh_r ? 7'd100 : qv);
      end
      ocv_pkg::OP_FIN: begin
        if (st.out_free) begin
          o_smp_r  <= val_r;
          o_done_r <= done_f_r;
          o_acc_r  <= acc_f_r;
          o_read_r <= reading_r;
          o_pct_r  <= charge_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign res.valid           = out_valid_r;
  assign res.smoothed_sample = o_smp_r;
  assign res.window_done     = o_done_r;
  assign res.window_accepted = o_acc_r;
  assign res.stable_reading  = o_read_r;
  assign res.charge_percent  = o_pct_r;

endmodule

/* src/battery_ocv_soc_estimator.sv */
// Top level of the battery open-circuit-voltage charge estimator
//
//  channel | dir | word
//  in_ch   | in  | adc_sample
//  out_ch  | out | smoothed_sample, window_done, window_accepted,
//          |     | stable_reading, charge_percent
//  cfg_ch  | in  | index, data (gain, variance limit, initial window, step)
//
// One word: the sorted insert shifts k entries up, with a RAM read and a RAM write
// for each shifted entry, and ends with a plain write if it settles at entry 0.
// A word that closes a window adds two RAM passes over the c middle entries and
// the bit-serial divider, and the charge fit runs when the average is accepted.
// The window RAM needs no clearing pass.
// The result register frees the input while the last word waits on out_ch.
`include "assert_macros.svh"

module battery_ocv_soc_estimator (
  input  logic     clk,
  input  logic     rst_n,
  ocv_in_if.sink   in_ch,
  ocv_out_if.source out_ch,
  ocv_cfg_if.sink  cfg_ch
);

  ocv_pkg::cmd_t  cmd;
  ocv_pkg::stat_t st;

  ocv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  ocv_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .adc_sample (in_ch.adc_sample),
    .cfg        (cfg_ch),
    .res        (out_ch)
  );

  `OCV_ASSERT(a_busy_after_accept, in_ch.valid && in_ch.ready |=> !in_ch.ready, "input taken while busy")
  `OCV_ASSERT_ALWAYS(a_acc_needs_done, out_ch.valid && out_ch.window_accepted |-> out_ch.window_done, "accept without window")
  `OCV_ASSERT(a_pct_range, out_ch.valid |-> out_ch.charge_percent <= 7'd100, "charge above 100")
  `OCV_ASSERT(a_div_wait, st.div_done |-> cmd.op == ocv_pkg::OP_DIV_WAIT, "divider done unexpected")

endmodule
